// ===== rtl/mcf_pkg.sv =====
// Shared types and constants for the MP3 module command framer.
package mcf_pkg;

    localparam int unsigned FRAME_LEN  = 10;
    localparam int unsigned IDX_W      = $clog2(FRAME_LEN);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FRAME_LEN - 1);

    localparam logic [4:0] VOL_MAX   = 5'd30;
    localparam logic [4:0] VOL_RESET = 5'd15;
    localparam logic [7:0] TRK_RESET = 8'd1;
    localparam logic [6:0] FOLD_MAX  = 7'd99;

    // Fixed frame bytes
    localparam logic [7:0] BYTE_START = 8'h7E;
    localparam logic [7:0] BYTE_VER   = 8'hFF;
    localparam logic [7:0] BYTE_LEN   = 8'h06;
    localparam logic [7:0] BYTE_FBACK = 8'h00;
    localparam logic [7:0] BYTE_END   = 8'hEF;

    // Command codes on the wire
    localparam logic [7:0] CODE_PLAY   = 8'h0D;
    localparam logic [7:0] CODE_PAUSE  = 8'h0E;
    localparam logic [7:0] CODE_STOP   = 8'h16;
    localparam logic [7:0] CODE_NEXT   = 8'h01;
    localparam logic [7:0] CODE_PREV   = 8'h02;
    localparam logic [7:0] CODE_SETVOL = 8'h06;
    localparam logic [7:0] CODE_TRACK  = 8'h03;
    localparam logic [7:0] CODE_FOLDER = 8'h0F;
    localparam logic [7:0] CODE_QSTAT  = 8'h3F;
    localparam logic [7:0] CODE_QCOUNT = 8'h48;

    typedef enum logic [3:0] {
        KIND_PLAY    = 4'd0,
        KIND_PAUSE   = 4'd1,
        KIND_STOP    = 4'd2,
        KIND_NEXT    = 4'd3,
        KIND_PREV    = 4'd4,
        KIND_SETVOL  = 4'd5,
        KIND_VOLUP   = 4'd6,
        KIND_VOLDOWN = 4'd7,
        KIND_TRACK   = 4'd8,
        KIND_FOLDER  = 4'd9,
        KIND_QSTAT   = 4'd10,
        KIND_QCOUNT  = 4'd11
    } kind_t;

    // One decoded frame plus the player state it reports
    typedef struct packed {
        logic [7:0]  code;
        logic [7:0]  p1;
        logic [7:0]  p2;
        logic [15:0] chk;
        logic        playing;
        logic [7:0]  track;
        logic [4:0]  volume;
    } frame_t;

endpackage

// ===== rtl/mp3_module_command_framer.sv =====
// Top level of the MP3 module command framer.
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready, total_tracks): sets the track count used
//   for next/prev wrap and play-track range checks. Always ready; write it
//   only while the block is idle.
//   in channel (in_valid/in_ready, kind/value/folder): one player command per
//   beat. Unless rejected, it updates volume, track and playing at acceptance.
//   out channel (out_valid/out_ready): an accepted command produces ten beats,
//   the serial frame 7E FF 06 cmd 00 p1 p2 chkH chkL EF, last_byte set on the
//   tenth. Each beat also carries the player state after that command.
//   Rejected commands (volume at limit, bad track or folder, unknown kind)
//   are taken like any other command and produce no beats.
// With the output idle, an accepted command is held in the decode register,
//   then in the serializer frame register, before the first byte is valid.
// Throughput: one frame byte per cycle while out_ready is high, frames going
//   out back to back; set by the output byte counter.
// A decoded frame waits in the decode register while the previous one is
//   still being sent, so the next command is taken before the output drains.
//   When out_ready is low the byte and counter hold; in_ready drops once the
//   decode register is full.
// Reset: volume 15, track 1, not playing, total_tracks 0, no frame pending.
module mp3_module_command_framer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] total_tracks,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [3:0] kind,
    input  logic [7:0] value,
    input  logic [6:0] folder,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] frame_byte,
    output logic       last_byte,
    output logic       playing,
    output logic [7:0] track_now,
    output logic [4:0] volume_now
);
    import mcf_pkg::*;

    logic   frm_valid;
    logic   frm_take;
    frame_t frm;

    // Config register is a plain load; never stalls.
    assign cfg_ready = 1'b1;

    // Decode stage: state update and frame contents, one command per beat.
    mcf_decoder u_decoder (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .total_tracks (total_tracks),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .value        (value),
        .folder       (folder),
        .frm_valid    (frm_valid),
        .frm          (frm),
        .frm_take     (frm_take)
    );

    // Output stage: walks the held frame one byte per beat.
    mcf_serializer u_serializer (
        .clk        (clk),
        .rst_n      (rst_n),
        .frm_valid  (frm_valid),
        .frm        (frm),
        .frm_take   (frm_take),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .frame_byte (frame_byte),
        .last_byte  (last_byte),
        .playing    (playing),
        .track_now  (track_now),
        .volume_now (volume_now)
    );

endmodule

// ===== rtl/mcf_decoder.sv =====
// Command decode, player state update and frame build.
module mcf_decoder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic [7:0]          total_tracks,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [3:0]          kind,
    input  logic [7:0]          value,
    input  logic [6:0]          folder,
    output logic                frm_valid,
    output mcf_pkg::frame_t     frm,
    input  logic                frm_take
);
    import mcf_pkg::*;

    logic [7:0]  tracks_reg;
    logic [4:0]  vol_reg, vol_next;
    logic [7:0]  trk_reg, trk_next;
    logic        play_reg, play_next;
    logic        frm_valid_reg;
    frame_t      frm_reg, frm_next;
    logic        emit;
    logic [7:0]  code, p1, p2;
    logic [8:0]  trk_inc;
    logic [15:0] sum;
    logic        in_beat;

    assign in_ready = !frm_valid_reg || frm_take;
    assign in_beat  = in_valid && in_ready;
    assign trk_inc  = {1'b0, trk_reg} + 9'd1;

    always_comb
    begin
        emit      = 1'b1;
        code      = CODE_QSTAT;
        p1        = 8'd0;
        p2        = 8'd0;
        vol_next  = vol_reg;
        trk_next  = trk_reg;
        play_next = play_reg;
        case (kind_t'(kind))
            KIND_PLAY:
            begin
                code      = CODE_PLAY;
                play_next = 1'b1;
            end
            KIND_PAUSE:
            begin
                code      = CODE_PAUSE;
                play_next = 1'b0;
            end
            KIND_STOP:
            begin
                code      = CODE_STOP;
                play_next = 1'b0;
            end
            KIND_NEXT:
            begin
                code     = CODE_NEXT;
                trk_next = (trk_inc > {1'b0, tracks_reg}) ? 8'd1 : trk_inc[7:0];
            end
            KIND_PREV:
            begin
                code     = CODE_PREV;
                trk_next = (trk_reg <= 8'd1) ? tracks_reg : trk_reg - 8'd1;
            end
            KIND_SETVOL:
            begin
                code     = CODE_SETVOL;
                vol_next = (value > {3'd0, VOL_MAX}) ? VOL_MAX : value[4:0];
                p2       = {3'd0, vol_next};
            end
            KIND_VOLUP:
            begin
                code     = CODE_SETVOL;
                emit     = (vol_reg < VOL_MAX);
                vol_next = emit ? vol_reg + 5'd1 : vol_reg;
                p2       = {3'd0, vol_next};
            end
            KIND_VOLDOWN:
            begin
                code     = CODE_SETVOL;
                emit     = (vol_reg != 5'd0);
                vol_next = emit ? vol_reg - 5'd1 : vol_reg;
                p2       = {3'd0, vol_next};
            end
            KIND_TRACK:
            begin
                code = CODE_TRACK;
                emit = (value != 8'd0) && (value <= tracks_reg);
                p2   = value;
                if (emit)
                begin
                    trk_next  = value;
                    play_next = 1'b1;
                end
            end
            KIND_FOLDER:
            begin
                code = CODE_FOLDER;
                emit = (folder != 7'd0) && (folder <= FOLD_MAX) && (value != 8'd0);
                p1   = {1'b0, folder};
                p2   = value;
                if (emit)
                    play_next = 1'b1;
            end
            KIND_QSTAT:  code = CODE_QSTAT;
            KIND_QCOUNT: code = CODE_QCOUNT;
            default:     emit = 1'b0;
        endcase
    end

    // Checksum: two's complement of version + length + code + feedback + params
    assign sum = 16'(BYTE_VER) + 16'(BYTE_LEN) + 16'(code) + 16'(BYTE_FBACK)
               + 16'(p1) + 16'(p2);

    always_comb
    begin
        frm_next.code    = code;
        frm_next.p1      = p1;
        frm_next.p2      = p2;
        frm_next.chk     = 16'd0 - sum;
        frm_next.playing = play_next;
        frm_next.track   = trk_next;
        frm_next.volume  = vol_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tracks_reg    <= 8'd0;
            vol_reg       <= VOL_RESET;
            trk_reg       <= TRK_RESET;
            play_reg      <= 1'b0;
            frm_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                tracks_reg <= total_tracks;
            if (in_beat)
            begin
                frm_valid_reg <= emit;
                if (emit)
                begin
                    vol_reg  <= vol_next;
                    trk_reg  <= trk_next;
                    play_reg <= play_next;
                end
            end
            else if (frm_take)
                frm_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat && emit)
            frm_reg <= frm_next;
    end

    assign frm_valid = frm_valid_reg;
    assign frm       = frm_reg;

endmodule

// ===== rtl/mcf_serializer.sv =====
// Frame serializer: sends one held frame as ten output beats.
module mcf_serializer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                frm_valid,
    input  mcf_pkg::frame_t     frm,
    output logic                frm_take,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          frame_byte,
    output logic                last_byte,
    output logic                playing,
    output logic [7:0]          track_now,
    output logic [4:0]          volume_now
);
    import mcf_pkg::*;

    logic                busy_reg;
    logic [IDX_W-1:0]    idx_reg;
    frame_t              frm_reg;
    logic                at_last;
    logic                done;

    assign at_last  = (idx_reg == IDX_LAST);
    assign done     = busy_reg && out_ready && at_last;
    assign frm_take = frm_valid && (!busy_reg || done);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (frm_take)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (done)
            busy_reg <= 1'b0;
        else if (busy_reg && out_ready)
            idx_reg <= idx_reg + IDX_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (frm_take)
            frm_reg <= frm;
    end

    always_comb
    begin
        case (idx_reg)
            IDX_W'(0): frame_byte = BYTE_START;
            IDX_W'(1): frame_byte = BYTE_VER;
            IDX_W'(2): frame_byte = BYTE_LEN;
            IDX_W'(3): frame_byte = frm_reg.code;
            IDX_W'(4): frame_byte = BYTE_FBACK;
            IDX_W'(5): frame_byte = frm_reg.p1;
            IDX_W'(6): frame_byte = frm_reg.p2;
            IDX_W'(7): frame_byte = frm_reg.chk[15:8];
            IDX_W'(8): frame_byte = frm_reg.chk[7:0];
            default:   frame_byte = BYTE_END;
        endcase
    end

    assign out_valid  = busy_reg;
    assign last_byte  = at_last;
    assign playing    = frm_reg.playing;
    assign track_now  = frm_reg.track;
    assign volume_now = frm_reg.volume;

endmodule

// ===== dv/tb_mp3_module_command_framer.sv =====
// Self-checking testbench for the MP3 module command framer.
`timescale 1ns / 100ps

module tb_mp3_module_command_framer;
    import mcf_pkg::*;

    // Kinds past the last command are ignored by the block
    localparam logic [3:0] KIND_SPARE_LO = 4'd12;
    localparam logic [3:0] KIND_SPARE_HI = 4'd15;

    localparam int DRAIN_CYCLES   = 4;     // quiet time before a track count write
    localparam int TAIL_CYCLES    = 20;    // quiet time after the last expected beat
    localparam int HOLD_CYCLES    = 120;   // long receiver back-off
    localparam int STALL_LIMIT    = 5000;  // cycles with no beat on any channel
    localparam int FRAMES_PER_RUN = 30;    // framed commands per random phase

    // How a stimulus row is checked
    typedef enum logic [1:0] {
        CHK_MODEL,   // expected frame from the predictor
        CHK_FRAME,   // frame typed into the row
        CHK_NONE     // command must be dropped, no frame
    } row_chk_t;

    typedef enum logic {
        ROW_CMD,
        ROW_TRACKS   // register write, value field carries total_tracks
    } row_op_t;

    typedef struct {
        row_op_t    op;
        row_chk_t   chk;
        logic [3:0] kind;
        logic [7:0] value;
        logic [6:0] folder;
        logic [7:0] code;
        logic [7:0] p1;
        logic [7:0] p2;
        logic       playing;
        logic [7:0] track;
        logic [4:0] volume;
    } row_t;

    // One outgoing frame byte plus the player state it carries
    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       playing;
        logic [7:0] track;
        logic [4:0] volume;
    } beat_t;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       cfg_valid    = 1'b0;
    logic       cfg_ready;
    logic [7:0] total_tracks = 8'd0;
    logic       in_valid     = 1'b0;
    logic       in_ready;
    logic [3:0] kind         = 4'd0;
    logic [7:0] value        = 8'd0;
    logic [6:0] folder       = 7'd0;
    logic       out_valid;
    logic       out_ready    = 1'b0;
    logic [7:0] frame_byte;
    logic       last_byte;
    logic       playing;
    logic [7:0] track_now;
    logic [4:0] volume_now;

    // Player state as the predictor sees it
    logic [4:0] vol_q    = VOL_RESET;
    logic [7:0] trk_q    = TRK_RESET;
    logic       play_q   = 1'b0;
    logic [7:0] tracks_q = 8'd0;

    beat_t frame_q  [$];   // frame bytes still owed by the block
    row_t  pinned_q [$];   // directed rows waiting for their command beat
    row_t  plan     [$];   // directed stimulus table

    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int errors        = 0;
    int beats_checked = 0;
    int frames_made   = 0;
    int rejects       = 0;
    int cfg_writes    = 0;
    int stall_cycles  = 0;

    logic hold_go   = 1'b0;
    logic hold_used = 1'b0;
    int   hold_left = 0;

    mp3_module_command_framer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .total_tracks (total_tracks),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .value        (value),
        .folder       (folder),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .frame_byte   (frame_byte),
        .last_byte    (last_byte),
        .playing      (playing),
        .track_now    (track_now),
        .volume_now   (volume_now)
    );

    always #1 clk = ~clk;

    task automatic flag_mismatch(input string what, input int got, input int want);
        errors++;
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
    endtask

    // Command decode: updates the kept state, says whether a frame goes out
    task automatic apply_command(input logic [3:0] k, input logic [7:0] v,
                                 input logic [6:0] f, output logic ok,
                                 output logic [7:0] code, output logic [7:0] p1,
                                 output logic [7:0] p2);
        logic [8:0] nxt;
        ok   = 1'b1;
        code = 8'd0;
        p1   = 8'd0;
        p2   = 8'd0;
        nxt  = 9'd0;
        case (k)
            KIND_PLAY:
            begin
                play_q = 1'b1;
                code   = CODE_PLAY;
            end
            KIND_PAUSE:
            begin
                play_q = 1'b0;
                code   = CODE_PAUSE;
            end
            KIND_STOP:
            begin
                play_q = 1'b0;
                code   = CODE_STOP;
            end
            KIND_NEXT:
            begin
                // 9-bit sum so track 255 wraps when the medium holds 255
                nxt = {1'b0, trk_q} + 9'd1;
                if (nxt > {1'b0, tracks_q})
                    nxt = 9'd1;
                trk_q = nxt[7:0];
                code  = CODE_NEXT;
            end
            KIND_PREV:
            begin
                // no tracks: prev from 1 lands on 0
                if (trk_q <= 8'd1)
                    trk_q = tracks_q;
                else
                    trk_q = trk_q - 8'd1;
                code = CODE_PREV;
            end
            KIND_SETVOL:
            begin
                vol_q = (v > 8'(VOL_MAX)) ? VOL_MAX : v[4:0];
                code  = CODE_SETVOL;
                p2    = 8'(vol_q);
            end
            KIND_VOLUP:
            begin
                if (vol_q >= VOL_MAX)
                begin
                    ok = 1'b0;
                end
                else
                begin
                    vol_q = vol_q + 5'd1;
                    code  = CODE_SETVOL;
                    p2    = 8'(vol_q);
                end
            end
            KIND_VOLDOWN:
            begin
                if (vol_q == 5'd0)
                begin
                    ok = 1'b0;
                end
                else
                begin
                    vol_q = vol_q - 5'd1;
                    code  = CODE_SETVOL;
                    p2    = 8'(vol_q);
                end
            end
            KIND_TRACK:
            begin
                if (v == 8'd0 || v > tracks_q)
                begin
                    ok = 1'b0;
                end
                else
                begin
                    trk_q  = v;
                    play_q = 1'b1;
                    code   = CODE_TRACK;
                    p2     = v;
                end
            end
            KIND_FOLDER:
            begin
                if (f == 7'd0 || f > FOLD_MAX || v == 8'd0)
                begin
                    ok = 1'b0;
                end
                else
                begin
                    play_q = 1'b1;
                    code   = CODE_FOLDER;
                    p1     = {1'b0, f};
                    p2     = v;
                end
            end
            KIND_QSTAT:  code = CODE_QSTAT;
            KIND_QCOUNT: code = CODE_QCOUNT;
            default:     ok = 1'b0;
        endcase
    endtask

    // Lay out the ten bytes of one frame and queue them
    task automatic queue_frame(input logic [7:0] code, input logic [7:0] p1,
                               input logic [7:0] p2, input logic pl,
                               input logic [7:0] trk, input logic [4:0] vol);
        logic [15:0] chk;
        logic [7:0]  bytes [0:FRAME_LEN-1];
        beat_t       b;
        chk = 16'h0000 - (16'(BYTE_VER) + 16'(BYTE_LEN) + 16'(code) + 16'(BYTE_FBACK)
                          + 16'(p1) + 16'(p2));
        bytes = '{BYTE_START, BYTE_VER, BYTE_LEN, code, BYTE_FBACK, p1, p2,
                  chk[15:8], chk[7:0], BYTE_END};
        for (int i = 0; i < FRAME_LEN; i++)
        begin
            b.data    = bytes[i];
            b.last    = (i == FRAME_LEN - 1);
            b.playing = pl;
            b.track   = trk;
            b.volume  = vol;
            frame_q.push_back(b);
        end
    endtask

    // Monitor: checks output beats, then predicts from the command beat.
    // Both in one process so a beat never races its own prediction.
    always @(posedge clk)
    begin
        beat_t      b;
        row_t       r;
        row_chk_t   mode;
        logic       ok;
        logic [7:0] code, p1, p2;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (frame_q.size() == 0)
                begin
                    flag_mismatch("frame beat with nothing owed", frame_byte, 0);
                end
                else
                begin
                    b = frame_q.pop_front();
                    beats_checked++;
                    if (frame_byte !== b.data)
                        flag_mismatch("frame_byte", frame_byte, b.data);
                    if (last_byte !== b.last)
                        flag_mismatch("last_byte", last_byte, b.last);
                    if (playing !== b.playing)
                        flag_mismatch("playing", playing, b.playing);
                    if (track_now !== b.track)
                        flag_mismatch("track_now", track_now, b.track);
                    if (volume_now !== b.volume)
                        flag_mismatch("volume_now", volume_now, b.volume);
                end
            end
            if (cfg_valid && cfg_ready)
                tracks_q = total_tracks;
            if (in_valid && in_ready)
            begin
                apply_command(kind, value, folder, ok, code, p1, p2);
                mode = CHK_MODEL;
                if (pinned_q.size() != 0)
                begin
                    r    = pinned_q.pop_front();
                    mode = r.chk;
                end
                if (mode == CHK_FRAME)
                begin
                    queue_frame(r.code, r.p1, r.p2, r.playing, r.track, r.volume);
                    frames_made++;
                end
                else if (mode == CHK_MODEL && ok)
                begin
                    queue_frame(code, p1, p2, play_q, trk_q, vol_q);
                    frames_made++;
                end
                else
                begin
                    rejects++;
                end
            end
        end
    end

    // One-shot long back-off, counted here so the sender keeps pushing
    always @(posedge clk)
    begin
        if (hold_go && !hold_used)
        begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver: random back-pressure, or never ready during the hold
    always @(posedge clk)
    begin
        if (!rst_n || hold_left != 0)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // Watchdog: any beat on any channel restarts the count
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Offer one command beat; returns in the step it is taken.
    // valid stays high into the next command unless a gap is drawn.
    task automatic offer_command(input logic [3:0] k, input logic [7:0] v,
                                 input logic [6:0] f);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        value    <= v;
        folder   <= f;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
    endtask

    // Register write only once every owed beat is out and the pipe is quiet
    task automatic write_tracks(input logic [7:0] t);
        in_valid <= 1'b0;
        @(posedge clk);
        while (frame_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid    <= 1'b1;
        total_tracks <= t;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // Random command, mostly well-formed, some spare kinds and bad arguments
    task automatic offer_random();
        logic [3:0] k;
        logic [7:0] v;
        logic [6:0] f;
        int         hi;
        if ($urandom_range(99) < 8)
            k = 4'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO));
        else
            k = 4'($urandom_range(KIND_QCOUNT, KIND_PLAY));
        v = 8'($urandom_range(255));
        f = 7'($urandom_range(127));
        hi = (tracks_q == 8'd0) ? 1 : tracks_q;
        case (k)
            KIND_TRACK:
                if ($urandom_range(99) < 75)
                    v = 8'($urandom_range(hi, 1));
            KIND_SETVOL:
                if ($urandom_range(99) < 50)
                    v = 8'($urandom_range(31));
            KIND_FOLDER:
            begin
                if ($urandom_range(99) < 80)
                    f = 7'($urandom_range(FOLD_MAX, 1));
                if ($urandom_range(99) < 10)
                    v = 8'd0;
            end
            default: ;
        endcase
        offer_command(k, v, f);
    endtask

    function automatic row_t row_model(input logic [3:0] k, input logic [7:0] v,
                                       input logic [6:0] f);
        row_t r;
        r        = '{op: ROW_CMD, chk: CHK_MODEL, default: '0};
        r.kind   = k;
        r.value  = v;
        r.folder = f;
        return r;
    endfunction

    function automatic row_t row_reject(input logic [3:0] k, input logic [7:0] v,
                                        input logic [6:0] f);
        row_t r;
        r     = row_model(k, v, f);
        r.chk = CHK_NONE;
        return r;
    endfunction

    function automatic row_t row_frame(input logic [3:0] k, input logic [7:0] v,
                                       input logic [6:0] f, input logic [7:0] code,
                                       input logic [7:0] p1, input logic [7:0] p2,
                                       input logic pl, input logic [7:0] trk,
                                       input logic [4:0] vol);
        row_t r;
        r         = row_model(k, v, f);
        r.chk     = CHK_FRAME;
        r.code    = code;
        r.p1      = p1;
        r.p2      = p2;
        r.playing = pl;
        r.track   = trk;
        r.volume  = vol;
        return r;
    endfunction

    function automatic row_t row_tracks(input logic [7:0] t);
        row_t r;
        r       = row_model(KIND_PLAY, t, 7'd0);
        r.op    = ROW_TRACKS;
        return r;
    endfunction

    initial
    begin
        // Directed table. Rows: kind, value, folder [, typed frame and state].
        // No tracks yet: query from reset state, prev to track 0, next back to 1.
        plan.push_back(row_frame(KIND_QSTAT, 8'd0, 7'd0, CODE_QSTAT, 8'd0, 8'd0,
                                 1'b0, 8'd1, 5'd15));
        plan.push_back(row_frame(KIND_PREV, 8'd0, 7'd0, CODE_PREV, 8'd0, 8'd0,
                                 1'b0, 8'd0, 5'd15));
        plan.push_back(row_frame(KIND_NEXT, 8'd0, 7'd0, CODE_NEXT, 8'd0, 8'd0,
                                 1'b0, 8'd1, 5'd15));
        plan.push_back(row_reject(KIND_TRACK, 8'd1, 7'd0));
        plan.push_back(row_reject(KIND_SPARE_LO, 8'hFF, 7'h7F));
        plan.push_back(row_reject(KIND_SPARE_HI, 8'h00, 7'h00));
        // Full medium: volume clamps and limits, track wrap both ways
        plan.push_back(row_tracks(8'd255));
        plan.push_back(row_frame(KIND_SETVOL, 8'd255, 7'd0, CODE_SETVOL, 8'd0, 8'd30,
                                 1'b0, 8'd1, 5'd30));
        plan.push_back(row_reject(KIND_VOLUP, 8'd0, 7'd0));
        plan.push_back(row_frame(KIND_SETVOL, 8'd0, 7'h7F, CODE_SETVOL, 8'd0, 8'd0,
                                 1'b0, 8'd1, 5'd0));
        plan.push_back(row_reject(KIND_VOLDOWN, 8'd0, 7'd0));
        plan.push_back(row_model(KIND_VOLUP, 8'd0, 7'd0));
        plan.push_back(row_frame(KIND_TRACK, 8'd255, 7'd0, CODE_TRACK, 8'd0, 8'd255,
                                 1'b1, 8'd255, 5'd1));
        plan.push_back(row_frame(KIND_NEXT, 8'd0, 7'd0, CODE_NEXT, 8'd0, 8'd0,
                                 1'b1, 8'd1, 5'd1));
        plan.push_back(row_frame(KIND_PREV, 8'd0, 7'd0, CODE_PREV, 8'd0, 8'd0,
                                 1'b1, 8'd255, 5'd1));
        plan.push_back(row_reject(KIND_TRACK, 8'd0, 7'd0));
        plan.push_back(row_model(KIND_PAUSE, 8'd0, 7'd0));
        // Folder bounds
        plan.push_back(row_reject(KIND_FOLDER, 8'd5, 7'd0));
        plan.push_back(row_reject(KIND_FOLDER, 8'd5, 7'd100));
        plan.push_back(row_reject(KIND_FOLDER, 8'd0, 7'd99));
        plan.push_back(row_frame(KIND_FOLDER, 8'd255, 7'd99, CODE_FOLDER, 8'd99, 8'd255,
                                 1'b1, 8'd255, 5'd1));
        plan.push_back(row_model(KIND_FOLDER, 8'd1, 7'd1));
        plan.push_back(row_model(KIND_STOP, 8'd0, 7'd0));
        plan.push_back(row_model(KIND_PLAY, 8'd0, 7'd0));
        plan.push_back(row_model(KIND_VOLDOWN, 8'd0, 7'd0));
        plan.push_back(row_model(KIND_QCOUNT, 8'd0, 7'd0));
        // Small medium: one past the end, then the end
        plan.push_back(row_tracks(8'd5));
        plan.push_back(row_reject(KIND_TRACK, 8'd6, 7'd0));
        plan.push_back(row_model(KIND_TRACK, 8'd5, 7'd0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        snd_idle_pct = 10;
        rcv_idle_pct = 30;
        foreach (plan[i])
        begin
            if (plan[i].op == ROW_TRACKS)
            begin
                write_tracks(plan[i].value);
            end
            else
            begin
                pinned_q.push_back(plan[i]);
                offer_command(plan[i].kind, plan[i].value, plan[i].folder);
            end
        end

        // Random phases: slow receiver, then slow sender, then flat out
        // with one long receiver hold so the input side backs up.
        for (int ph = 0; ph < 3; ph++)
        begin
            int goal;
            case (ph)
                0:
                begin
                    snd_idle_pct = 17;
                    rcv_idle_pct = 82;
                    write_tracks(8'($urandom_range(12, 2)));
                end
                1:
                begin
                    snd_idle_pct = 82;
                    rcv_idle_pct = 17;
                    write_tracks(8'd255);
                end
                default:
                begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                    write_tracks(8'd1);
                    hold_go <= 1'b1;
                end
            endcase
            goal = frames_made + FRAMES_PER_RUN;
            while (frames_made < goal)
                offer_random();
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (frame_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (frame_q.size() != 0)
            flag_mismatch("frame beats never seen", frame_q.size(), 0);

        $display("Run: %0d commands framed, %0d dropped, %0d frame beats checked",
                 frames_made, rejects, beats_checked);
        $display("Track count written %0d times, three back-pressure mixes plus a long hold",
                 cfg_writes);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
